/* sv/sida_pkg.sv */
package sida_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned MIN_WIDTH_W = 5;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned NUM_DIGITS  = 10;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned BCD_W       = NUM_DIGITS * DIGIT_W;
  localparam int unsigned SHIFT_CNT_W = $clog2(VALUE_W);
  localparam int unsigned DIGIT_IDX_W = $clog2(NUM_DIGITS);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

  // Finished conversion handed from the converter to the character emitter.
  typedef struct packed {
    bcd_t                   bcd;
    logic                   neg;
    logic [MIN_WIDTH_W-1:0] width;
  } conv_t;

endpackage

/* sv/sida_in_if.sv */
interface sida_in_if;
  import sida_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [VALUE_W-1:0]     value;
  logic        [MIN_WIDTH_W-1:0] min_width;

  modport source (output valid, value, min_width, input ready);
  modport sink (input valid, value, min_width, output ready);
endinterface

/* sv/sida_out_if.sv */
interface sida_out_if;
  import sida_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ascii_char;
  logic              is_last;

  modport source (output valid, ascii_char, is_last, input ready);
  modport sink (input valid, ascii_char, is_last, output ready);
endinterface

/* sv/sida_dabble.sv */
module sida_dabble #(
  parameter int unsigned MAX_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [sida_pkg::VALUE_W-1:0]     value_i,
  input  logic [sida_pkg::MIN_WIDTH_W-1:0] min_width_i,
  output logic                             ready_o,
  output logic                             done_o,
  output sida_pkg::conv_t                  conv_o,
  input  logic                             take_i
);
  import sida_pkg::*;

  function automatic bcd_t adjust(input bcd_t b);
    bcd_t r;
    r = b;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (b[i] >= DIGIT_W'(5)) begin
        r[i] = b[i] + DIGIT_W'(3);
      end
    end
    return r;
  endfunction

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [SHIFT_CNT_W-1:0] cnt_q, cnt_d;
  logic [VALUE_W-1:0]     mag_q, mag_d;
  bcd_t                   bcd_q, bcd_d;
  logic                   neg_q, neg_d;
  logic [MIN_WIDTH_W-1:0] width_q, width_d;
  bcd_t                   bcd_adj;

  assign ready_o = !busy_q && !done_q;
  assign done_o  = done_q;
  assign conv_o  = '{bcd: bcd_q, neg: neg_q, width: width_q};
  assign bcd_adj = adjust(bcd_q);

  always_comb begin
    busy_d  = busy_q;
    done_d  = done_q;
    cnt_d   = cnt_q;
    mag_d   = mag_q;
    bcd_d   = bcd_q;
    neg_d   = neg_q;
    width_d = width_q;
    if (done_q && take_i) begin
      done_d = 1'b0;
    end
    if (start_i && ready_o) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      bcd_d  = '0;
      neg_d  = value_i[VALUE_W-1];
      // Unsigned negate also covers the most negative value.
      mag_d  = value_i[VALUE_W-1] ? (VALUE_W'(0) - value_i) : value_i;
      if (32'(min_width_i) > MAX_WIDTH) begin
        width_d = MIN_WIDTH_W'(MAX_WIDTH);
      end else begin
        width_d = min_width_i;
      end
    end else if (busy_q) begin
      // Add-3 correction, then shift one magnitude bit into the BCD word.
      bcd_d = bcd_t'({bcd_adj[NUM_DIGITS-1:0], mag_q[VALUE_W-1]});
      mag_d = {mag_q[VALUE_W-2:0], 1'b0};
      cnt_d = cnt_q + SHIFT_CNT_W'(1);
      if (cnt_q == SHIFT_CNT_W'(VALUE_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    bcd_q   <= bcd_d;
    neg_q   <= neg_d;
    width_q <= width_d;
  end

endmodule

/* sv/sida_emit.sv */
module sida_emit #(
  parameter int unsigned MAX_WIDTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        conv_valid_i,
  input  sida_pkg::conv_t             conv_i,
  output logic                        conv_take_o,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [sida_pkg::CHAR_W-1:0] ascii_char_o,
  output logic                        is_last_o
);
  import sida_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_WIDTH + 1);

  logic            active_q, active_d;
  logic            sign_q, sign_d;
  logic [CntW-1:0] pos_q, pos_d;
  bcd_t            bcd_q, bcd_d;

  logic                   fire;
  logic                   ld_ready;
  logic [CntW-1:0]        ndig;
  logic [CntW-1:0]        text_len;
  logic [CntW-1:0]        width_c;
  logic [CntW-1:0]        total;
  logic [DIGIT_IDX_W-1:0] sel;
  logic                   in_digits;

  assign fire        = valid_o && ready_i;
  assign ld_ready    = !active_q || (fire && is_last_o);
  assign conv_take_o = conv_valid_i && ld_ready;

  // Significant digits: one past the highest nonzero digit, at least one.
  always_comb begin
    ndig = CntW'(1);
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (conv_i.bcd[i] != '0) begin
        ndig = CntW'(i + 1);
      end
    end
  end

  assign text_len = ndig + CntW'(conv_i.neg);
  assign width_c  = CntW'(conv_i.width);
  assign total    = (width_c > text_len) ? width_c : text_len;

  // pos_q counts characters still to go after the current one.
  assign in_digits    = pos_q < CntW'(NUM_DIGITS);
  assign sel          = DIGIT_IDX_W'(pos_q);
  assign valid_o      = active_q;
  assign is_last_o    = !sign_q && (pos_q == '0);

  always_comb begin
    if (sign_q) begin
      ascii_char_o = CHAR_MINUS;
    end else if (in_digits) begin
      ascii_char_o = CHAR_ZERO + CHAR_W'(bcd_q[sel]);
    end else begin
      ascii_char_o = CHAR_ZERO;
    end
  end

  always_comb begin
    active_d = active_q;
    sign_d   = sign_q;
    pos_d    = pos_q;
    bcd_d    = bcd_q;
    if (conv_take_o) begin
      active_d = 1'b1;
      sign_d   = conv_i.neg;
      pos_d    = total - CntW'(1);
      bcd_d    = conv_i.bcd;
    end else if (fire) begin
      if (is_last_o) begin
        active_d = 1'b0;
      end else begin
        sign_d = 1'b0;
        pos_d  = pos_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      sign_q   <= 1'b0;
      pos_q    <= '0;
    end else begin
      active_q <= active_d;
      sign_q   <= sign_d;
      pos_q    <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
  end

endmodule

/* sv/signed_int_to_decimal_ascii.sv */
// Converts a signed 32-bit integer to decimal ASCII, most significant character
// first, one character per output transaction, with is_last on the final one.
// Negative values start with '-', and '0' characters are inserted after the
// sign until the text holds at least min_width characters (min_width is
// clamped to MAX_WIDTH). A bit-serial double-dabble converter works on each
// number after the input transaction; its result is then handed to the
// character emitter, which sends one character per cycle while the sink is
// ready. The converter starts on the next number while the emitter is still
// sending. A finished conversion waits until the emitter has sent the last
// character of the previous number, so a stalled sink can also hold back
// the converter.
module signed_int_to_decimal_ascii #(
  parameter int unsigned MAX_WIDTH = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  sida_in_if.sink    in_i,
  sida_out_if.source out_o
);
  import sida_pkg::*;

  logic  conv_done;
  logic  conv_take;
  conv_t conv;

  sida_dabble #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_dabble (
    .clk_i,
    .rst_ni,
    .start_i    (in_i.valid),
    .value_i    (in_i.value),
    .min_width_i(in_i.min_width),
    .ready_o    (in_i.ready),
    .done_o     (conv_done),
    .conv_o     (conv),
    .take_i     (conv_take)
  );

  sida_emit #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_emit (
    .clk_i,
    .rst_ni,
    .conv_valid_i(conv_done),
    .conv_i      (conv),
    .conv_take_o (conv_take),
    .valid_o     (out_o.valid),
    .ready_i     (out_o.ready),
    .ascii_char_o(out_o.ascii_char),
    .is_last_o   (out_o.is_last)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("converter accepted a transaction while busy");

  a_more_after_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !out_o.is_last |=> out_o.valid)
    else $error("text ended without is_last");

  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.ascii_char == CHAR_MINUS) |-> !out_o.is_last)
    else $error("sign emitted as final character");

  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.ascii_char == CHAR_MINUS) ||
      ((out_o.ascii_char >= CHAR_ZERO) && (out_o.ascii_char <= CHAR_NINE)))
    else $error("illegal character emitted");

endmodule

/* bench/sida_scoreboard.sv */
module sida_scoreboard #(
  parameter int unsigned MAX_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  sida_in_if   in_mon,
  sida_out_if  out_mon,
  output int   fail_cnt_o,
  output int   pending_o,
  output int   chars_o
);
  import sida_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  text_char_t exp_chars[$];

  // Queue the decimal text of one number, sign first, pad zeros after the sign.
  function automatic void queue_text(input logic signed [VALUE_W-1:0] value,
                                     input logic [MIN_WIDTH_W-1:0] min_width);
    logic [VALUE_W-1:0] mag;
    logic               neg;
    logic [CHAR_W-1:0]  digs [NUM_DIGITS];
    int unsigned        w;
    int unsigned        ndig;
    int unsigned        len;
    int unsigned        pad;
    int unsigned        total;
    text_char_t         tc;
    neg = value[VALUE_W-1];
    mag = value;
    // Unsigned negation keeps the most negative value exact.
    if (neg) mag = ~mag + 1'b1;
    w = (min_width > MAX_WIDTH) ? MAX_WIDTH : min_width;
    ndig = 0;
    do begin
      digs[ndig] = CHAR_ZERO + CHAR_W'(mag % 10);
      mag = mag / 10;
      ndig++;
    end while (mag != 0 && ndig < NUM_DIGITS);
    len = ndig + (neg ? 1 : 0);
    pad = (w > len) ? w - len : 0;
    total = len + pad;
    for (int unsigned i = 0; i < total; i++) begin
      if (neg && i == 0) begin
        tc.ch = CHAR_MINUS;
      end else if (i < pad + (neg ? 1 : 0)) begin
        tc.ch = CHAR_ZERO;
      end else begin
        tc.ch = digs[total - 1 - i];
      end
      tc.last = (i == total - 1);
      exp_chars.push_back(tc);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    int         errs;
    text_char_t want;
    errs = 0;
    if (!rst_ni) begin
      fail_cnt_o <= 0;
      pending_o  <= 0;
      chars_o    <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        queue_text(in_mon.value, in_mon.min_width);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (exp_chars.size() == 0) begin
          $error("unexpected character %h with is_last %b", out_mon.ascii_char,
                 out_mon.is_last);
          errs++;
        end else begin
          want = exp_chars.pop_front();
          if (out_mon.ascii_char !== want.ch) begin
            $error("ascii_char mismatch: expected %h actual %h", want.ch,
                   out_mon.ascii_char);
            errs++;
          end
          if (out_mon.is_last !== want.last) begin
            $error("is_last mismatch: expected %b actual %b", want.last,
                   out_mon.is_last);
            errs++;
          end
        end
        chars_o <= chars_o + 1;
      end
      fail_cnt_o <= fail_cnt_o + errs;
      pending_o  <= exp_chars.size();
    end
  end

endmodule

/* bench/signed_int_to_decimal_ascii_tb.sv */
module signed_int_to_decimal_ascii_tb;
  import sida_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_WIDTH  = 16;
  localparam int          N_RANDOM   = 100;
  localparam int          PAUSE_AT   = 50;
  localparam int          QUIET_FROM = 80;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic sink_ready = 1'b0;
  bit   quiet = 1'b0;
  int   stall_cnt = 0;
  int   fail_cnt;
  int   pending;
  int   chars_seen;
  int   n_sent = 0;

  sida_in_if  in_if ();
  sida_out_if out_if ();

  assign out_if.ready = sink_ready;

  signed_int_to_decimal_ascii #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  sida_scoreboard #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_scoreboard (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_if),
    .out_mon   (out_if),
    .fail_cnt_o(fail_cnt),
    .pending_o (pending),
    .chars_o   (chars_seen)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver stalls at random until quiet is set, each burst counted down in stall_cnt.
  always @(posedge clk_i) begin
    if (stall_cnt != 0) begin
      stall_cnt  <= stall_cnt - 1;
      sink_ready <= 1'b0;
    end else if (rst_ni && !quiet && $urandom_range(0, 5) == 0) begin
      stall_cnt  <= $urandom_range(0, 4);
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  task automatic send_number(input logic signed [VALUE_W-1:0] value,
                             input logic [MIN_WIDTH_W-1:0] min_width);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.value     <= value;
    in_if.min_width <= min_width;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    n_sent++;
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    longint lo;
    longint hi;
    longint v;
    int     d;
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return 32'sh8000_0001;
          default: return 0;
        endcase
      end
      default: begin
        // Aim at a given digit count, either sign.
        d  = $urandom_range(1, 10);
        lo = 1;
        repeat (d - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (hi > 64'sd2147483647) hi = 64'sd2147483647;
        if (d == 1) lo = 0;
        v = lo + (longint'($urandom) % (hi - lo + 1));
        if ($urandom_range(0, 1)) v = -v;
        return VALUE_W'(v);
      end
    endcase
  endfunction

  initial begin
    in_if.valid     <= 1'b0;
    in_if.value     <= '0;
    in_if.min_width <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_number(0, 0);
    send_number(0, 16);
    send_number(1, 1);
    send_number(-1, 0);
    send_number(-1, 1);
    send_number(-1, 2);
    send_number(32'sh7FFF_FFFF, 0);
    send_number(32'sh8000_0000, 0);
    send_number(32'sh8000_0000, 16);
    send_number(32'sh8000_0001, 12);
    send_number(-5, 4);
    send_number(-5, 31);
    send_number(42, 31);
    send_number(5, 17);
    send_number(123, 2);
    send_number(12345, 5);
    send_number(9, 0);
    send_number(10, 0);
    send_number(-10, 3);
    send_number(999999999, 0);
    send_number(1000000000, 0);
    send_number(-1000000000, 11);
    send_number(7, 16);
    send_number(-7, 15);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == PAUSE_AT) begin
        // Hold off until the block has drained.
        in_if.valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      if (i == QUIET_FROM) quiet = 1'b1;
      send_number(pick_value(),
                  ($urandom_range(0, 9) == 0) ? MIN_WIDTH_W'($urandom_range(17, 31))
                                              : MIN_WIDTH_W'($urandom_range(0, 16)));
    end
    in_if.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    @(negedge clk_i);

    $display("Sent %0d numbers and checked %0d characters", n_sent, chars_seen);
    $display("Covered both extreme values, signed padding, and widths 0 to 31");
    if (fail_cnt == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* filelist.f */
sv/sida_pkg.sv
sv/sida_in_if.sv
sv/sida_out_if.sv
sv/sida_dabble.sv
sv/sida_emit.sv
sv/signed_int_to_decimal_ascii.sv
bench/sida_scoreboard.sv
bench/signed_int_to_decimal_ascii_tb.sv
